// ===== rtl/core/mtep_pkg.sv =====
package mtep_pkg;

  // parser phase codes
  localparam logic [2:0] PH_DELTA     = 3'd0;
  localparam logic [2:0] PH_STATUS    = 3'd1;
  localparam logic [2:0] PH_DATA1     = 3'd2;
  localparam logic [2:0] PH_DATA2     = 3'd3;
  localparam logic [2:0] PH_META_TYPE = 3'd4;
  localparam logic [2:0] PH_LENGTH    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD   = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;
  localparam logic [1:0] KIND_TRUNC   = 2'd3;

  // status codes and masks
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;

  localparam int TDATA_OUT_W = 112;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] delta_ticks;
    logic [7:0]  status;
    logic [7:0]  meta_kind;
    logic [1:0]  data_count;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_in_event;
  } result_t;

endpackage

// ===== rtl/core/mtep_decode.sv =====
module mtep_decode
  import mtep_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [7:0]    data_byte,
  input  logic          track_end,
  output logic          emit,
  output result_t       res
);

  logic [2:0]  phase_r,  phase_nxt;
  logic [31:0] delta_r,  delta_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  meta_r,   meta_nxt;
  logic [31:0] len_r,    len_nxt;
  logic [31:0] left_r,   left_nxt;
  logic [7:0]  first_r,  first_nxt;
  logic        skip_r,   skip_nxt;

  always_comb begin
    logic        done;
    logic        bad;
    logic [31:0] len_new;
    logic [31:0] left_dec;
    logic [3:0]  hi;

    phase_nxt  = phase_r;
    delta_nxt  = delta_r;
    status_nxt = status_r;
    meta_nxt   = meta_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    first_nxt  = first_r;
    skip_nxt   = skip_r;
    emit       = 1'b0;
    res        = '0;
    done       = 1'b0;
    bad        = 1'b0;
    len_new    = {len_r[24:0], data_byte[6:0]};
    left_dec   = left_r - 32'd1;
    hi         = status_r[7:4];

    if (skip_r) begin
      // swallow bytes after a bad status until track end
      if (track_end) begin
        done = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_DELTA: begin
          delta_nxt = {delta_r[24:0], data_byte[6:0]};
          if (!data_byte[7]) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          status_nxt = data_byte;
          if (data_byte == ST_SYSEX) begin
            meta_nxt  = '0;
            len_nxt   = '0;
            phase_nxt = PH_LENGTH;
          end else if (data_byte == ST_META) begin
            phase_nxt = PH_META_TYPE;
          end else if (data_byte[7] && data_byte[7:4] != HI_SYSTEM) begin
            phase_nxt = PH_DATA1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DATA1: begin
          first_nxt = data_byte;
          if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
            emit              = 1'b1;
            res.result_kind   = KIND_HEADER;
            res.delta_ticks   = delta_r;
            res.status        = status_r;
            res.data_count    = 2'd1;
            res.data_first    = data_byte;
            res.last_in_event = 1'b1;
            done              = 1'b1;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit              = 1'b1;
          res.result_kind   = KIND_HEADER;
          res.delta_ticks   = delta_r;
          res.status        = status_r;
          res.data_count    = 2'd2;
          res.data_first    = first_r;
          res.data_second   = data_byte;
          res.last_in_event = 1'b1;
          done              = 1'b1;
        end
        PH_META_TYPE: begin
          meta_nxt  = data_byte;
          len_nxt   = '0;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_nxt = len_new;
          if (!data_byte[7]) begin
            emit            = 1'b1;
            res.result_kind = KIND_HEADER;
            res.delta_ticks = delta_r;
            res.status      = status_r;
            res.meta_kind   = meta_r;
            if (len_new == '0) begin
              res.last_in_event = 1'b1;
              done              = 1'b1;
            end else begin
              res.payload_length = len_new;
              left_nxt           = len_new;
              phase_nxt          = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          left_nxt           = left_dec;
          emit               = 1'b1;
          res.result_kind    = KIND_PAYLOAD;
          res.delta_ticks    = delta_r;
          res.status         = status_r;
          res.meta_kind      = meta_r;
          res.payload_length = len_r;
          res.payload_byte   = data_byte;
          res.last_in_event  = (left_dec == '0);
          done               = (left_dec == '0);
        end
        default: begin
          done = 1'b1;
        end
      endcase

      if (bad) begin
        emit              = 1'b1;
        res               = '0;
        res.result_kind   = KIND_BAD;
        res.delta_ticks   = delta_r;
        res.status        = data_byte;
        res.last_in_event = 1'b1;
      end else if (!done && track_end) begin
        // truncated event replaces whatever this byte produced
        emit               = 1'b1;
        res                = '0;
        res.result_kind    = KIND_TRUNC;
        res.delta_ticks    = delta_nxt;
        res.status         = status_nxt;
        res.meta_kind      = meta_nxt;
        res.payload_length = len_nxt;
        res.last_in_event  = 1'b1;
      end
    end

    if (bad || done || track_end) begin
      phase_nxt  = PH_DELTA;
      delta_nxt  = '0;
      status_nxt = '0;
      meta_nxt   = '0;
      len_nxt    = '0;
      left_nxt   = '0;
      first_nxt  = '0;
      skip_nxt   = bad && !track_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      delta_r  <= '0;
      status_r <= '0;
      meta_r   <= '0;
      len_r    <= '0;
      left_r   <= '0;
      first_r  <= '0;
      skip_r   <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      delta_r  <= delta_nxt;
      status_r <= status_nxt;
      meta_r   <= meta_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      first_r  <= first_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

// ===== rtl/core/mtep_out_reg.sv =====
module mtep_out_reg
  import mtep_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_res,
  input  logic    take,
  output logic    valid,
  output result_t res
);

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign valid = valid_r;
  assign res   = res_r;

endmodule

// ===== rtl/core/midi_track_event_parser_top.sv =====
// channel  | dir | tdata                          | tuser        | tlast
// in_      | in  | data_byte[7:0]                 | -            | track_end
// out_     | out | event fields, 106 bits + pad   | result_kind  | last_in_event
//
// one request per cycle while out_ is not stalled: a byte sits in the input register,
// phase decode and 32-bit accumulate/compare feed the result register combinationally
// a result is offered on out_ once its byte has passed the input and result registers
// rst_n is synchronous, active low, and returns the parser to expecting a delta time
// a stalled out_ side holds the result; one more byte waits in the input register,
// after which in_tready drops
module midi_track_event_parser_top
  import mtep_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tlast,   // track_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // delta_ticks[31:0], status[39:32], meta_kind[47:40], data_count[49:48],
  // data_first[57:50], data_second[65:58], payload_length[97:66],
  // payload_byte[105:98], zero pad[111:106]
  output logic [TDATA_OUT_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // result_kind
  output logic                   out_tlast   // last_in_event
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       advance;
  logic       emit;
  logic       out_valid;
  result_t    dec_res;
  result_t    out_res;

  // the held byte moves on when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // phase decode and event state
  mtep_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (in_byte_r),
    .track_end (in_end_r),
    .emit      (emit),
    .res       (dec_res)
  );

  // result register
  mtep_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && emit),
    .load_res (dec_res),
    .take     (out_tready),
    .valid    (out_valid),
    .res      (out_res)
  );

  assign out_tvalid = out_valid;
  assign out_tuser  = out_res.result_kind;
  assign out_tlast  = out_res.last_in_event;
  assign out_tdata  = {6'd0,
                       out_res.payload_byte,
                       out_res.payload_length,
                       out_res.data_second,
                       out_res.data_first,
                       out_res.data_count,
                       out_res.meta_kind,
                       out_res.status,
                       out_res.delta_ticks};

endmodule

// ===== bench/midi_track_event_parser_top_test.sv =====
`timescale 1ns / 1ps

module midi_track_event_parser_top_test;
  import mtep_pkg::*;

  localparam int HOLD_CYCLES     = 80;    // long receiver hold-off in the last phase
  localparam int STALL_LIMIT     = 2000;  // cycles without any request before giving up
  localparam int ITEMS_PER_PHASE = 225;
  localparam int MAX_PRINTS      = 30;

  // one track byte as offered on in_, with an optional hand-typed expectation
  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       typed;
    result_t    want;
  } track_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;   // data_byte
  logic                   in_tlast = 1'b0;    // track_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // delta_ticks, status, meta_kind, data_count, data_first, data_second,
  // payload_length, payload_byte, zero pad
  logic [TDATA_OUT_W-1:0] out_tdata;
  logic [1:0]             out_tuser;          // result_kind
  logic                   out_tlast;          // last_in_event

  midi_track_event_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  track_byte_t track_bytes[$];
  result_t     expected_events[$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  holds_done = 0;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  results_seen = 0;
  int  kind_seen[4] = '{default: 0};
  int  input_stall_cycles = 0;

  // parser state mirrored by the predictor
  logic [2:0]  parse_phase;
  logic [31:0] delta_acc;
  logic [7:0]  held_status;
  logic [7:0]  held_meta;
  logic [31:0] len_acc;
  logic [31:0] bytes_left;
  logic [7:0]  held_first;
  logic        skip_to_end;

  task automatic clear_parser();
    parse_phase = PH_DELTA;
    delta_acc   = '0;
    held_status = '0;
    held_meta   = '0;
    len_acc     = '0;
    bytes_left  = '0;
    held_first  = '0;
    skip_to_end = 1'b0;
  endtask

  function automatic result_t make_result(input logic [1:0] kind, input logic [31:0] delta,
                                          input logic [7:0] st, input logic [7:0] meta,
                                          input logic [1:0] cnt, input logic [7:0] d1,
                                          input logic [7:0] d2, input logic [31:0] plen,
                                          input logic [7:0] pbyte, input logic last);
    result_t r;
    r.result_kind    = kind;
    r.delta_ticks    = delta;
    r.status         = st;
    r.meta_kind      = meta;
    r.data_count     = cnt;
    r.data_first     = d1;
    r.data_second    = d2;
    r.payload_length = plen;
    r.payload_byte   = pbyte;
    r.last_in_event  = last;
    return r;
  endfunction

  // advance the event parse by one track byte, giving the result it causes if any
  task automatic parse_track_byte(input logic [7:0] b, input logic eot,
                                  output bit has_res, output result_t res);
    logic [3:0] hi;
    bit         finish;
    has_res = 1'b0;
    res     = '0;
    finish  = 1'b0;
    hi      = held_status[7:4];
    if (skip_to_end) begin
      if (eot) clear_parser();
      return;
    end
    case (parse_phase)
      PH_DELTA: begin
        delta_acc = (delta_acc << 7) + {25'd0, b[6:0]};
        if (!b[7]) parse_phase = PH_STATUS;
      end
      PH_STATUS: begin
        held_status = b;
        hi = b[7:4];
        if (b == ST_SYSEX) begin
          held_meta   = '0;
          len_acc     = '0;
          parse_phase = PH_LENGTH;
        end else if (b == ST_META) begin
          parse_phase = PH_META_TYPE;
        end else if (hi >= 4'h8 && hi != HI_SYSTEM) begin
          parse_phase = PH_DATA1;
        end else begin
          // running status or system status: report, then drop bytes until track end
          res = make_result(KIND_BAD, delta_acc, b, '0, '0, '0, '0, '0, '0, 1'b1);
          has_res = 1'b1;
          clear_parser();
          skip_to_end = !eot;
          return;
        end
      end
      PH_DATA1: begin
        held_first = b;
        if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
          res = make_result(KIND_HEADER, delta_acc, held_status, '0, 2'd1, b, '0, '0, '0,
                            1'b1);
          has_res = 1'b1;
          finish  = 1'b1;
        end else begin
          parse_phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res = make_result(KIND_HEADER, delta_acc, held_status, '0, 2'd2, held_first, b, '0,
                          '0, 1'b1);
        has_res = 1'b1;
        finish  = 1'b1;
      end
      PH_META_TYPE: begin
        held_meta   = b;
        len_acc     = '0;
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        len_acc = (len_acc << 7) + {25'd0, b[6:0]};
        if (!b[7]) begin
          has_res = 1'b1;
          if (len_acc == 0) begin
            // empty payload: the header closes the event
            res = make_result(KIND_HEADER, delta_acc, held_status, held_meta, '0, '0, '0,
                              '0, '0, 1'b1);
            finish = 1'b1;
          end else begin
            res = make_result(KIND_HEADER, delta_acc, held_status, held_meta, '0, '0, '0,
                              len_acc, '0, 1'b0);
            bytes_left  = len_acc;
            parse_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 32'd1;
        res = make_result(KIND_PAYLOAD, delta_acc, held_status, held_meta, '0, '0, '0,
                          len_acc, b, bytes_left == 0);
        has_res = 1'b1;
        finish  = (bytes_left == 0);
      end
      default: clear_parser();
    endcase
    if (finish) begin
      clear_parser();
    end else if (eot) begin
      // track ended inside an event: one truncation result replaces anything else
      res = make_result(KIND_TRUNC, delta_acc, held_status, held_meta, '0, '0, '0, len_acc,
                        '0, 1'b1);
      has_res = 1'b1;
      clear_parser();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eot, input logic typed,
                            input result_t want);
    track_byte_t t;
    t.b     = b;
    t.eot   = eot;
    t.typed = typed;
    t.want  = want;
    track_bytes.insert(track_bytes.size(), t);
  endtask

  // short directed run; hand-typed rows are the ones readable at a glance
  task automatic load_directed();
    // note on at delta zero, track end on the completing byte
    queue_byte(8'h00, 1'b0, 1'b0, '0);
    queue_byte(8'h90, 1'b0, 1'b0, '0);
    queue_byte(8'h7F, 1'b0, 1'b0, '0);
    queue_byte(8'h00, 1'b1, 1'b1, make_result(KIND_HEADER, 32'd0, 8'h90, 8'h00, 2'd2,
                                              8'h7F, 8'h00, 32'd0, 8'h00, 1'b1));
    // longest four-byte delta, program change with a data byte that has bit 7 set
    queue_byte(8'hFF, 1'b0, 1'b0, '0);
    queue_byte(8'hFF, 1'b0, 1'b0, '0);
    queue_byte(8'hFF, 1'b0, 1'b0, '0);
    queue_byte(8'h7F, 1'b0, 1'b0, '0);
    queue_byte(8'hC5, 1'b0, 1'b0, '0);
    queue_byte(8'h80, 1'b0, 1'b1, make_result(KIND_HEADER, 32'h0FFF_FFFF, 8'hC5, 8'h00,
                                              2'd1, 8'h80, 8'h00, 32'd0, 8'h00, 1'b1));
    // zero-length meta event
    queue_byte(8'h00, 1'b0, 1'b0, '0);
    queue_byte(8'hFF, 1'b0, 1'b0, '0);
    queue_byte(8'h2F, 1'b0, 1'b0, '0);
    queue_byte(8'h00, 1'b0, 1'b1, make_result(KIND_HEADER, 32'd0, 8'hFF, 8'h2F, 2'd0,
                                              8'h00, 8'h00, 32'd0, 8'h00, 1'b1));
    // sysex with two payload bytes
    queue_byte(8'h00, 1'b0, 1'b0, '0);
    queue_byte(8'hF0, 1'b0, 1'b0, '0);
    queue_byte(8'h02, 1'b0, 1'b0, '0);
    queue_byte(8'hAA, 1'b0, 1'b0, '0);
    queue_byte(8'h55, 1'b0, 1'b0, '0);
    // running status is rejected, then bytes are dropped up to track end
    queue_byte(8'h00, 1'b0, 1'b0, '0);
    queue_byte(8'h45, 1'b0, 1'b1, make_result(KIND_BAD, 32'd0, 8'h45, 8'h00, 2'd0, 8'h00,
                                              8'h00, 32'd0, 8'h00, 1'b1));
    queue_byte(8'h12, 1'b0, 1'b0, '0);
    queue_byte(8'h34, 1'b1, 1'b0, '0);
    // controller cut short by track end
    queue_byte(8'h00, 1'b0, 1'b0, '0);
    queue_byte(8'hB0, 1'b0, 1'b0, '0);
    queue_byte(8'h07, 1'b1, 1'b1, make_result(KIND_TRUNC, 32'd0, 8'hB0, 8'h00, 2'd0, 8'h00,
                                              8'h00, 32'd0, 8'h00, 1'b1));
  endtask

  function automatic logic [7:0] random_data_byte();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return {1'b0, 7'($urandom)};
  endfunction

  // one random event, mostly well formed; sometimes cut short, rejected or plain noise
  task automatic gen_event(input bit close_track);
    logic [7:0] evt_bytes[$];
    logic [7:0] st;
    int         nd, plen, pick, cut, i, fmt, k;
    bit         is_bad;
    is_bad = 1'b0;
    if ($urandom_range(32) == 0) begin
      nd = $urandom_range(1, 8);
      for (i = 0; i < nd; i++) queue_byte(8'($urandom), i == nd - 1, 1'b0, '0);
      return;
    end
    // delta time, now and then five groups so that it wraps
    nd = ($urandom_range(9) == 0) ? 5 : $urandom_range(1, 2);
    for (i = 0; i < nd; i++) evt_bytes.insert(evt_bytes.size(), {i != nd - 1, 7'($urandom)});
    pick = $urandom_range(99);
    if (pick < 60) begin
      st = {4'($urandom_range(8, 14)), 4'($urandom)};
      evt_bytes.insert(evt_bytes.size(), st);
      evt_bytes.insert(evt_bytes.size(), random_data_byte());
      if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
        evt_bytes.insert(evt_bytes.size(), random_data_byte());
    end else if (pick < 92) begin
      if (pick < 75) begin
        evt_bytes.insert(evt_bytes.size(), ST_META);
        evt_bytes.insert(evt_bytes.size(), 8'($urandom));
      end else begin
        evt_bytes.insert(evt_bytes.size(), ST_SYSEX);
      end
      plen = ($urandom_range(9) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 6);
      if (plen >= 128) begin
        evt_bytes.insert(evt_bytes.size(), {1'b1, 7'(plen >> 7)});
        evt_bytes.insert(evt_bytes.size(), {1'b0, 7'(plen)});
      end else begin
        fmt = $urandom_range(5);
        if (fmt == 4) begin
          // leading zero group
          evt_bytes.insert(evt_bytes.size(), 8'h80);
        end else if (fmt == 5) begin
          // five groups whose top bits fall off the 32-bit length
          k = $urandom_range(1, 7);
          evt_bytes.insert(evt_bytes.size(), {1'b1, 3'(k), 4'h0});
          evt_bytes.insert(evt_bytes.size(), 8'h80);
          evt_bytes.insert(evt_bytes.size(), 8'h80);
          evt_bytes.insert(evt_bytes.size(), 8'h80);
        end
        evt_bytes.insert(evt_bytes.size(), {1'b0, 7'(plen)});
      end
      for (i = 0; i < plen; i++) evt_bytes.insert(evt_bytes.size(), 8'($urandom));
    end else begin
      is_bad = 1'b1;
      st = $urandom_range(1) ? {1'b0, 7'($urandom)} : 8'($urandom_range(8'hF1, 8'hFE));
      evt_bytes.insert(evt_bytes.size(), st);
    end

    if (is_bad) begin
      if ($urandom_range(4) == 0) begin
        for (i = 0; i < evt_bytes.size(); i++)
          queue_byte(evt_bytes[i], i == evt_bytes.size() - 1, 1'b0, '0);
      end else begin
        for (i = 0; i < evt_bytes.size(); i++) queue_byte(evt_bytes[i], 1'b0, 1'b0, '0);
        nd = $urandom_range(0, 4);
        for (i = 0; i <= nd; i++) queue_byte(8'($urandom), i == nd, 1'b0, '0);
      end
    end else if ($urandom_range(19) == 0) begin
      cut = $urandom_range(0, evt_bytes.size() - 2);
      for (i = 0; i <= cut; i++) queue_byte(evt_bytes[i], i == cut, 1'b0, '0);
    end else begin
      for (i = 0; i < evt_bytes.size(); i++)
        queue_byte(evt_bytes[i], close_track && i == evt_bytes.size() - 1, 1'b0, '0);
    end
  endtask

  task automatic build_random(input int n_bytes);
    int target;
    target = track_bytes.size() + n_bytes;
    while (track_bytes.size() < target) gen_event($urandom_range(7) == 0);
  endtask

  // offer queued bytes on in_, predicting each one as its request completes
  task automatic send_all();
    track_byte_t t;
    bit          has_res;
    result_t     res;
    while (track_bytes.size() != 0) begin
      t = track_bytes.pop_front();
      while ($urandom_range(99) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= t.b;
      in_tlast  <= t.eot;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      parse_track_byte(t.b, t.eot, has_res, res);
      if (t.typed) expected_events.insert(expected_events.size(), t.want);
      else if (has_res) expected_events.insert(expected_events.size(), res);
      bytes_sent++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h", results_seen, name,
                                got, want));
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.result_kind    = out_tuser;
    got.delta_ticks    = out_tdata[31:0];
    got.status         = out_tdata[39:32];
    got.meta_kind      = out_tdata[47:40];
    got.data_count     = out_tdata[49:48];
    got.data_first     = out_tdata[57:50];
    got.data_second    = out_tdata[65:58];
    got.payload_length = out_tdata[97:66];
    got.payload_byte   = out_tdata[105:98];
    got.last_in_event  = out_tlast;
    kind_seen[got.result_kind]++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = expected_events.pop_front();
      compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
      compare_field("delta_ticks", got.delta_ticks, want.delta_ticks);
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("meta_kind", 32'(got.meta_kind), 32'(want.meta_kind));
      compare_field("data_count", 32'(got.data_count), 32'(want.data_count));
      compare_field("data_first", 32'(got.data_first), 32'(want.data_first));
      compare_field("data_second", 32'(got.data_second), 32'(want.data_second));
      compare_field("payload_length", got.payload_length, want.payload_length);
      compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
      compare_field("last_in_event", 32'(got.last_in_event), 32'(want.last_in_event));
    end
    results_seen++;
  endtask

  // result side: every completed request is checked against the oldest expectation
  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) check_result();
    if (in_tvalid && in_tready === 1'b0) input_stall_cycles++;
  end

  // receiver: random backpressure, or one long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // no request on either side for too long means the block has hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request for %0d cycles, %0d results still expected",
             STALL_LIMIT, expected_events.size());
    $display("midi_track_event_parser_top_test: errors");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: directed table then random, sender idles lightly, receiver heavily
    tx_idle_pct = 26;
    rx_idle_pct = 67;
    load_directed();
    build_random(ITEMS_PER_PHASE);
    send_all();

    // phase two: the other way round
    tx_idle_pct = 67;
    rx_idle_pct = 26;
    build_random(ITEMS_PER_PHASE);
    send_all();

    // phase three: full rate, opening with a long receiver hold-off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    build_random(ITEMS_PER_PHASE);
    send_all();
    in_tvalid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d track bytes, checked %0d results: %0d headers, %0d payload bytes,",
             bytes_sent, results_seen, kind_seen[KIND_HEADER], kind_seen[KIND_PAYLOAD]);
    $display("%0d bad status, %0d truncated; %0d hold-offs, %0d cycles with input stalled",
             kind_seen[KIND_BAD], kind_seen[KIND_TRUNC], holds_done, input_stall_cycles);
    if (mismatches == 0) begin
      $display("midi_track_event_parser_top_test: clean");
    end else begin
      $display("midi_track_event_parser_top_test: errors");
    end
    $finish;
  end

endmodule
